### rtl/serial_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// serial_frame_receiver assertion macros
// Concurrent assertion forms for the frame receiver parser.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RECEIVER_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with the property held only while a qualifier is high.
`define SFR_ASSERT_WHEN(lbl, clk, rst_n, qual, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (prop)) \
        else $error(msg);

`endif

### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Types, phase codes, error codes and register indexes of the frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned DEVICE_W    = 3;
    localparam int unsigned ERR_W       = 3;
    localparam int unsigned PHASE_W     = 4;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [PHASE_W-1:0] PH_HUNT1 = 4'd0;
    localparam logic [PHASE_W-1:0] PH_HUNT2 = 4'd1;
    localparam logic [PHASE_W-1:0] PH_ID    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_LEN   = 4'd3;
    localparam logic [PHASE_W-1:0] PH_CMD   = 4'd4;
    localparam logic [PHASE_W-1:0] PH_ADDL  = 4'd5;
    localparam logic [PHASE_W-1:0] PH_ADDH  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_DATA  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CHKL  = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CHKH  = 4'd9;
    localparam logic [PHASE_W-1:0] PH_END1  = 4'd10;
    localparam logic [PHASE_W-1:0] PH_END2  = 4'd11;

    localparam logic [BYTE_W-1:0] MAX_DEVICE   = 8'h05;
    localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd5;
    localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd4;

    localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] ERR_HEADER2 = 3'd1;
    localparam logic [ERR_W-1:0] ERR_ID      = 3'd2;
    localparam logic [ERR_W-1:0] ERR_LENGTH  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_COMMAND = 3'd4;
    localparam logic [ERR_W-1:0] ERR_ADDRESS = 3'd5;
    localparam logic [ERR_W-1:0] ERR_TAIL    = 3'd6;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_ONE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_TWO  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_ONE    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_TWO    = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_CODE   = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SERVO_CODE  = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR   = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SERVO_MATCH = 8'd7;

    localparam logic [BYTE_W-1:0] RST_HEADER = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_TAIL   = 8'hEE;

    typedef struct packed {
        logic [BYTE_W-1:0] header_one;
        logic [BYTE_W-1:0] header_two;
        logic [BYTE_W-1:0] tail_one;
        logic [BYTE_W-1:0] tail_two;
        logic [BYTE_W-1:0] base_code;
        logic [BYTE_W-1:0] servo_code;
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] servo_match;
    } cfg_t;

    // Field order matches m_tdata, highest bits first.
    typedef struct packed {
        logic [ERR_W-1:0]    error_code;
        logic [ADDR_W-1:0]   check_word;
        logic                reply_kind;
        logic [DEVICE_W-1:0] device_id;
        logic                frame_ok;
        logic [BYTE_W-1:0]   payload_index;
        logic [BYTE_W-1:0]   payload_byte;
    } beat_data_t;

    typedef struct packed {
        logic       payload_valid;
        logic       frame_done;
        beat_data_t data;
    } result_t;

endpackage

`default_nettype wire

### rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver
// Byte-serial frame parser: header, id, length, command, address, payload,
// check word and tail, with payload streaming and per-frame status.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and returns exactly one result beat per
// byte, sustaining one byte per cycle while the result stream is not stalled;
// each byte passes the input register, then the result register. The rate is
// set by the frame phase register, updated per byte. Payload beats carry
// tuser high and should be dropped by the consumer unless the frame's end
// beat (tlast high) reports frame_ok. The check word is passed through
// unverified. The configuration port is always ready; write it only while
// no bytes are in flight.
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_receiver (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input byte stream; s_tdata: rx_byte[7:0]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sfr_pkg::S_TDATA_W-1:0]   s_tdata,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: payload_byte[7:0], payload_index[15:8], frame_ok[16],
    //          device_id[19:17], reply_kind[20], check_word[36:21],
    //          error_code[39:37]
    output logic [sfr_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: payload_valid[0]
    output logic                                 m_tuser,
    // m_tlast: frame_done
    output logic                                 m_tlast,
    // Configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfr_pkg::*;

    cfg_t              cfg;
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_data;
    logic              take;
    result_t           result;

    sfr_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata[BYTE_W-1:0]),
        .take       (take),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sfr_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (byte_valid),
        .in_byte  (byte_data),
        .take     (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .result   (result)
    );

    assign m_tdata = result.data;
    assign m_tuser = result.payload_valid;
    assign m_tlast = result.frame_done;

endmodule

`default_nettype wire

### rtl/sfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfr_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfr_pkg::cfg_t                       cfg
);
    import sfr_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_one  <= RST_HEADER;
            cfg_reg.header_two  <= RST_HEADER;
            cfg_reg.tail_one    <= RST_TAIL;
            cfg_reg.tail_two    <= RST_TAIL;
            cfg_reg.base_code   <= '0;
            cfg_reg.servo_code  <= '0;
            cfg_reg.base_addr   <= '0;
            cfg_reg.servo_match <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_HEADER_ONE:  cfg_reg.header_one  <= cfg_data[BYTE_W-1:0];
                REG_HEADER_TWO:  cfg_reg.header_two  <= cfg_data[BYTE_W-1:0];
                REG_TAIL_ONE:    cfg_reg.tail_one    <= cfg_data[BYTE_W-1:0];
                REG_TAIL_TWO:    cfg_reg.tail_two    <= cfg_data[BYTE_W-1:0];
                REG_BASE_CODE:   cfg_reg.base_code   <= cfg_data[BYTE_W-1:0];
                REG_SERVO_CODE:  cfg_reg.servo_code  <= cfg_data[BYTE_W-1:0];
                REG_BASE_ADDR:   cfg_reg.base_addr   <= cfg_data[ADDR_W-1:0];
                REG_SERVO_MATCH: cfg_reg.servo_match <= cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register for received bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfr_in_stage (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [sfr_pkg::BYTE_W-1:0]  s_byte,
    input  wire logic                        take,
    output logic                             byte_valid,
    output logic [sfr_pkg::BYTE_W-1:0]       byte_data
);
    import sfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_byte;
        end
    end

endmodule

`default_nettype wire

### rtl/sfr_parser.sv
// ----------------------------------------------------------------------------
// sfr_parser
// Frame phase register, captured frame fields and the registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sfr_pkg::cfg_t               cfg,
    input  wire logic                        in_valid,
    input  wire logic [sfr_pkg::BYTE_W-1:0]  in_byte,
    output logic                             take,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output sfr_pkg::result_t                 result
);
    import sfr_pkg::*;

    logic [PHASE_W-1:0]  phase_reg,   phase_next;
    logic [DEVICE_W-1:0] device_reg,  device_next;
    logic [BYTE_W-1:0]   length_reg,  length_next;
    logic                kind_reg,    kind_next;
    logic [BYTE_W-1:0]   count_reg,   count_next;
    logic [ADDR_W-1:0]   check_reg,   check_next;
    logic                out_valid_reg, out_valid_next;
    result_t             result_reg,  result_next;

    logic [ADDR_W-1:0] addr_sel;
    logic [BYTE_W-1:0] count_inc;
    logic [BYTE_W-1:0] data_len;
    logic              ok;
    logic              report;
    logic [ERR_W-1:0]  err;

    assign take     = in_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

    assign addr_sel  = kind_reg ? cfg.servo_match : cfg.base_addr;
    assign count_inc = count_reg + 8'd1;
    assign data_len  = length_reg - LEN_OVERHEAD;

    always_comb begin
        phase_next  = phase_reg;
        device_next = device_reg;
        length_next = length_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        check_next  = check_reg;
        report      = 1'b0;
        ok          = 1'b0;
        err         = ERR_NONE;
        result_next = '0;

        unique case (phase_reg)
            PH_HUNT2: begin
                if (in_byte == cfg.header_two) begin
                    phase_next = PH_ID;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_HEADER2;
                end
            end
            PH_ID: begin
                if (in_byte < MAX_DEVICE) begin
                    device_next = in_byte[DEVICE_W-1:0];
                    phase_next  = PH_LEN;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_ID;
                end
            end
            PH_LEN: begin
                if (in_byte >= MIN_LENGTH) begin
                    length_next = in_byte;
                    phase_next  = PH_CMD;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_LENGTH;
                end
            end
            PH_CMD: begin
                priority if (in_byte == cfg.base_code) begin
                    kind_next  = 1'b0;
                    phase_next = PH_ADDL;
                end else if (in_byte == cfg.servo_code) begin
                    kind_next  = 1'b1;
                    phase_next = PH_ADDL;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_COMMAND;
                end
            end
            PH_ADDL: begin
                if (in_byte == addr_sel[BYTE_W-1:0]) begin
                    phase_next = PH_ADDH;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_ADDRESS;
                end
            end
            PH_ADDH: begin
                if (in_byte == addr_sel[ADDR_W-1:BYTE_W]) begin
                    count_next = '0;
                    phase_next = PH_DATA;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_ADDRESS;
                end
            end
            PH_DATA: begin
                result_next.payload_valid      = 1'b1;
                result_next.data.payload_byte  = in_byte;
                result_next.data.payload_index = count_reg;
                count_next                     = count_inc;
                if (count_inc >= data_len) begin
                    phase_next = PH_CHKL;
                end
            end
            PH_CHKL: begin
                check_next = {check_reg[ADDR_W-1:BYTE_W], in_byte};
                phase_next = PH_CHKH;
            end
            PH_CHKH: begin
                check_next = {in_byte, check_reg[BYTE_W-1:0]};
                phase_next = PH_END1;
            end
            PH_END1: begin
                if (in_byte == cfg.tail_one) begin
                    phase_next = PH_END2;
                end else begin
                    phase_next = PH_HUNT1;
                    report     = 1'b1;
                    err        = ERR_TAIL;
                end
            end
            PH_END2: begin
                phase_next = PH_HUNT1;
                report     = 1'b1;
                if (in_byte == cfg.tail_two) begin
                    ok = 1'b1;
                end else begin
                    err = ERR_TAIL;
                end
            end
            default: begin
                if (in_byte == cfg.header_one) begin
                    device_next = '0;
                    length_next = '0;
                    kind_next   = 1'b0;
                    count_next  = '0;
                    check_next  = '0;
                    phase_next  = PH_HUNT2;
                end else begin
                    phase_next = PH_HUNT1;
                end
            end
        endcase

        if (report) begin
            result_next.frame_done      = 1'b1;
            result_next.data.frame_ok   = ok;
            result_next.data.device_id  = device_reg;
            result_next.data.reply_kind = kind_reg;
            result_next.data.check_word = check_reg;
            result_next.data.error_code = err;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT1;
            device_reg    <= '0;
            length_reg    <= '0;
            kind_reg      <= 1'b0;
            count_reg     <= '0;
            check_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg  <= phase_next;
                device_reg <= device_next;
                length_reg <= length_next;
                kind_reg   <= kind_next;
                count_reg  <= count_next;
                check_reg  <= check_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

`include "serial_frame_receiver_assert.svh"

    `SFR_ASSERT_WHEN(a_payload_not_done, aclk, aresetn, out_valid_reg && result_reg.payload_valid, !result_reg.frame_done, "payload beat also marks frame end")
    `SFR_ASSERT_WHEN(a_ok_is_clean, aclk, aresetn, out_valid_reg && result_reg.data.frame_ok, result_reg.frame_done && result_reg.data.error_code == ERR_NONE, "good frame beat carries an error")
    `SFR_ASSERT_WHEN(a_reject_has_code, aclk, aresetn, out_valid_reg && result_reg.frame_done && !result_reg.data.frame_ok, result_reg.data.error_code != ERR_NONE, "rejected frame without error code")
    `SFR_ASSERT_WHEN(a_count_in_range, aclk, aresetn, phase_reg == PH_DATA, count_reg < data_len, "payload count past frame length")

endmodule

`default_nettype wire
